// File: design/assert_macros.svh
// assertion macros shared by the packet fragment planner rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define PFP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pfp_pkg.sv
// package for the packet fragment planner: widths, codes, job and divider types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pfp_pkg;

  localparam int LENGTH_BITS   = 16;
  localparam int MAX_FRAGMENTS = 64;
  localparam int COEF_BITS     = 16;
  localparam int CNT_BITS      = $clog2(MAX_FRAGMENTS + 1);
  localparam int N_BITS        = LENGTH_BITS + 1;
  localparam int DIV_CNT_BITS  = $clog2(LENGTH_BITS + 1);
  localparam int MODE_BITS     = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = LENGTH_BITS;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
  localparam int STATUS_BITS   = 3;

  localparam logic [MODE_BITS-1:0] MODE_PASS    = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_SPLIT   = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_NOSPLIT = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT_MODE    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_PART_SIZE = 2'd1;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_FRAGMENT  = 3'd0,
    ST_WHOLE     = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_TOO_MANY  = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_CLASS,
    FS_DIV1,
    FS_DIV2,
    FS_CALC,
    FS_PUSH
  } front_state_t;

  typedef struct packed {
    status_e_t              status;
    logic [LENGTH_BITS-1:0] len;
    logic [COEF_BITS-1:0]   coef;
    logic [COEF_BITS-1:0]   cnt;
    logic                   last;
    logic [LENGTH_BITS-1:0] q;
    logic [CNT_BITS-1:0]    n;
  } job_t;

  typedef struct packed {
    logic                   start;
    logic [LENGTH_BITS-1:0] dividend;
    logic [LENGTH_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [LENGTH_BITS-1:0] quot;
    logic [LENGTH_BITS-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: design/pfp_channels.sv
// request and configuration channel interfaces of the packet fragment planner
// depends on pfp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface pfp_in_if;
  logic                            valid;
  logic                            ready;
  logic [pfp_pkg::LENGTH_BITS-1:0] packet_length;
  logic [pfp_pkg::COEF_BITS-1:0]   split_coefficient;
  logic [pfp_pkg::COEF_BITS-1:0]   split_counter;
  logic                            packet_is_last;

  modport source (output valid, packet_length, split_coefficient, split_counter,
                  packet_is_last, input ready);
  modport sink (input valid, packet_length, split_coefficient, split_counter,
                packet_is_last, output ready);
endinterface

interface pfp_out_if;
  logic                            valid;
  logic                            ready;
  logic [pfp_pkg::STATUS_BITS-1:0] status;
  logic [pfp_pkg::LENGTH_BITS-1:0] fragment_offset;
  logic [pfp_pkg::LENGTH_BITS-1:0] fragment_length;
  logic [pfp_pkg::COEF_BITS-1:0]   out_coefficient;
  logic [pfp_pkg::COEF_BITS-1:0]   out_counter;
  logic                            fragment_is_last;
  logic                            end_of_run;

  modport source (output valid, status, fragment_offset, fragment_length,
                  out_coefficient, out_counter, fragment_is_last, end_of_run,
                  input ready);
  modport sink (input valid, status, fragment_offset, fragment_length,
                out_coefficient, out_counter, fragment_is_last, end_of_run,
                output ready);
endinterface

interface pfp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pfp_pkg::CFG_IDX_BITS-1:0]  reg_index;
  logic [pfp_pkg::CFG_DATA_BITS-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// File: design/pfp_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on pfp_pkg
`timescale 1ns / 1ps
`default_nettype none

module pfp_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pfp_pkg::div_req_t req,
  output pfp_pkg::div_rsp_t      rsp
);
  import pfp_pkg::*;

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [DIV_CNT_BITS-1:0] step_r, step_nxt;
  logic [LENGTH_BITS-1:0]  quot_r;
  logic [LENGTH_BITS-1:0]  rem_r;
  logic [LENGTH_BITS-1:0]  divisor_r;
  logic [LENGTH_BITS:0]    shifted;
  logic [LENGTH_BITS:0]    diff;
  logic                    ge;

  always_comb begin
    shifted = {rem_r, quot_r[LENGTH_BITS-1]};
    ge      = (shifted >= {1'b0, divisor_r});
    diff    = shifted - {1'b0, divisor_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = DIV_CNT_BITS'(LENGTH_BITS);
    end else if (busy_r) begin
      step_nxt = step_r - DIV_CNT_BITS'(1);
      if (step_r == DIV_CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot_r    <= req.dividend;
      rem_r     <= '0;
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      quot_r <= {quot_r[LENGTH_BITS-2:0], ge};
      rem_r  <= ge ? diff[LENGTH_BITS-1:0] : shifted[LENGTH_BITS-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

// File: design/pfp_front.sv
// front end: accepts packet descriptors, classifies them and plans the split
// depends on pfp_pkg and pfp_channels; drives the shared divider pfp_div
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pfp_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  pfp_in_if.sink                               in_ch,
  input  wire logic [pfp_pkg::MODE_BITS-1:0]   limit_mode,
  input  wire logic [pfp_pkg::LENGTH_BITS-1:0] max_part_size,
  output pfp_pkg::div_req_t                    div_req,
  input  wire pfp_pkg::div_rsp_t               div_rsp,
  output logic                                 push,
  output pfp_pkg::job_t                        push_job,
  input  wire logic                            full
);
  import pfp_pkg::*;

  front_state_t           state_r, state_nxt;
  logic [LENGTH_BITS-1:0] len_r;
  logic [COEF_BITS-1:0]   coef_r;
  logic [COEF_BITS-1:0]   cnt_r;
  logic                   last_r;
  logic [CNT_BITS-1:0]    n_r;
  logic [LENGTH_BITS-1:0] q_r;
  job_t                   job_r;

  status_e_t                      cls_status;
  logic                           needs_split;
  logic                           split_mode;
  logic                           fits;
  logic [N_BITS-1:0]              n_ceil;
  logic [N_BITS-1:0]              n_even;
  logic                           too_many;
  logic [COEF_BITS-1:0]           coef_prod;
  logic [COEF_BITS-1:0]           cnt_prod;
  logic [COEF_BITS-1:0]           first_cnt;
  job_t                           single_job;
  job_t                           frag_job;

  // classification of the latched descriptor
  always_comb begin
    split_mode  = (limit_mode == MODE_SPLIT) || (limit_mode == MODE_NOSPLIT);
    fits        = (max_part_size == '0) || (max_part_size >= len_r);
    needs_split = 1'b0;
    if (len_r == '0) begin
      cls_status = ST_EMPTY;
    end else if (!split_mode || fits) begin
      cls_status = ST_WHOLE;
    end else if (limit_mode == MODE_NOSPLIT) begin
      cls_status = ST_TOO_LARGE;
    end else begin
      cls_status  = ST_FRAGMENT;
      needs_split = 1'b1;
    end
  end

  // part count, rounded up then made even
  always_comb begin
    n_ceil   = {1'b0, div_rsp.quot} + N_BITS'(div_rsp.rem != '0);
    n_even   = n_ceil + N_BITS'(n_ceil[0]);
    too_many = (n_even > N_BITS'(MAX_FRAGMENTS));
  end

  always_comb begin
    coef_prod = coef_r * COEF_BITS'(n_r);
    cnt_prod  = cnt_r * COEF_BITS'(n_r);
    first_cnt = cnt_prod - COEF_BITS'(n_r) + COEF_BITS'(1);
  end

  always_comb begin
    single_job.status = (state_r == FS_DIV1) ? ST_TOO_MANY : cls_status;
    single_job.len    = len_r;
    single_job.coef   = coef_r;
    single_job.cnt    = cnt_r;
    single_job.last   = last_r;
    single_job.q      = '0;
    single_job.n      = CNT_BITS'(1);

    frag_job.status = ST_FRAGMENT;
    frag_job.len    = len_r;
    frag_job.coef   = coef_prod;
    frag_job.cnt    = first_cnt;
    frag_job.last   = last_r;
    frag_job.q      = q_r;
    frag_job.n      = n_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_IDLE:  if (in_ch.valid) state_nxt = FS_CLASS;
      FS_CLASS: state_nxt = needs_split ? FS_DIV1 : FS_PUSH;
      FS_DIV1: begin
        if (div_rsp.done) state_nxt = too_many ? FS_PUSH : FS_DIV2;
      end
      FS_DIV2:  if (div_rsp.done) state_nxt = FS_CALC;
      FS_CALC:  state_nxt = FS_PUSH;
      FS_PUSH:  if (!full) state_nxt = FS_IDLE;
      default:  state_nxt = FS_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready      = 1'b0;
    push             = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = len_r;
    div_req.divisor  = max_part_size;
    case (state_r)
      FS_IDLE:  in_ch.ready = 1'b1;
      FS_CLASS: div_req.start = needs_split;
      FS_DIV1: begin
        div_req.start   = div_rsp.done && !too_many;
        div_req.divisor = LENGTH_BITS'(n_even[CNT_BITS-1:0]);
      end
      FS_PUSH:  push = 1'b1;
      default:  push = 1'b0;
    endcase
  end

  assign push_job = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      FS_IDLE: begin
        if (in_ch.valid) begin
          len_r  <= in_ch.packet_length;
          coef_r <= in_ch.split_coefficient;
          cnt_r  <= in_ch.split_counter;
          last_r <= in_ch.packet_is_last;
        end
      end
      FS_CLASS: job_r <= single_job;
      FS_DIV1: begin
        if (div_rsp.done) begin
          n_r   <= n_even[CNT_BITS-1:0];
          job_r <= single_job;
        end
      end
      FS_DIV2: if (div_rsp.done) q_r <= div_rsp.quot;
      FS_CALC: job_r <= frag_job;
      default: job_r <= job_r;
    endcase
  end

  `PFP_ASSERT_IMPL(a_push_count_range, push,
    (push_job.n != '0) && (push_job.n <= CNT_BITS'(MAX_FRAGMENTS)),
    "job pushed with a part count out of range")
  `PFP_ASSERT_IMPL(a_div_done_in_div, div_rsp.done,
    (state_r == FS_DIV1) || (state_r == FS_DIV2),
    "divider finished outside a divide state")

endmodule

`default_nettype wire

// File: design/pfp_queue.sv
// two-entry job queue between the front end and the back end
// depends on pfp_pkg
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pfp_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire pfp_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output pfp_pkg::job_t      head,
  output logic               empty
);
  import pfp_pkg::*;

  job_t                 mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r, count_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                   wr_ptr_r + QPTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                   rd_ptr_r + QPTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  `PFP_ASSERT_NEXT(a_queue_count_step, do_push && !do_pop,
    count_r == $past(count_r) + QCNT_BITS'(1),
    "queue fill count lost a job")

endmodule

`default_nettype wire

// File: design/pfp_back.sv
// back end: walks the queued job and, while out_ch does not stall, drives one
// fragment descriptor per cycle; depends on pfp_pkg and pfp_channels
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pfp_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pfp_pkg::job_t head,
  input  wire logic          empty,
  output logic               pop,
  pfp_out_if.source          out_ch
);
  import pfp_pkg::*;

  logic [CNT_BITS-1:0]    idx_r, idx_nxt;
  logic [LENGTH_BITS-1:0] off_r, off_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [STATUS_BITS-1:0] status_r;
  logic [LENGTH_BITS-1:0] offset_r;
  logic [LENGTH_BITS-1:0] length_r;
  logic [COEF_BITS-1:0]   coef_r;
  logic [COEF_BITS-1:0]   counter_r;
  logic                   is_last_r;
  logic                   eor_r;
  logic                   emit;
  logic                   fin;

  assign emit = !empty && (!out_valid_r || out_ch.ready);
  assign fin  = (idx_r == head.n - CNT_BITS'(1));
  assign pop  = emit && fin;

  always_comb begin
    idx_nxt       = idx_r;
    off_nxt       = off_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (fin) begin
        idx_nxt = '0;
        off_nxt = '0;
      end else begin
        idx_nxt = idx_r + CNT_BITS'(1);
        off_nxt = off_r + head.q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      off_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      off_r       <= off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status_r  <= head.status;
      offset_r  <= off_r;
      length_r  <= fin ? head.len - off_r : head.q;
      coef_r    <= head.coef;
      counter_r <= head.cnt + COEF_BITS'(idx_r);
      is_last_r <= fin ? head.last : 1'b0;
      eor_r     <= fin;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = status_r;
  assign out_ch.fragment_offset  = offset_r;
  assign out_ch.fragment_length  = length_r;
  assign out_ch.out_coefficient  = coef_r;
  assign out_ch.out_counter      = counter_r;
  assign out_ch.fragment_is_last = is_last_r;
  assign out_ch.end_of_run       = eor_r;

  `PFP_ASSERT_IMPL(a_index_in_job, !empty, idx_r < head.n,
    "fragment index ran past the part count")
  `PFP_ASSERT_IMPL(a_index_idle_zero, empty, (idx_r == '0) && (off_r == '0),
    "fragment walk not rewound between jobs")

endmodule

`default_nettype wire

// File: design/packet_fragment_planner_top.sv
// Packet fragment planner, top level: configuration registers and the
// front end, job queue, divider and back end. Depends on pfp_pkg,
// pfp_channels, pfp_div, pfp_front, pfp_queue and pfp_back.
//
// in_ch takes one packet descriptor per request; out_ch returns its
// fragment descriptors in order, end_of_run marking the last one of a packet.
// cfg_ch writes limit_mode (index 0) and max_part_size (index 1); it is
// always ready. It must be written only while the block is idle; the
// block does not enforce this. A packet that passes whole, is too large
// or is empty gives one result: the front end classifies it, pushes one
// job and returns to idle for the next packet. An oversize packet in
// split mode runs a serial division on the shared one-bit-per-cycle
// divider; with too many parts it is flagged and pushed as one job.
// Otherwise a second division by the even part count gives the part size,
// and the back end emits one fragment per cycle while out_ch does not stall.
// The queue of two jobs lets the front end plan the next packet while the
// back end still emits fragments. When out_ch stalls, the output register
// holds its descriptor, the queue fills and then in_ch drops ready.
// Reset (rst_n low, synchronous) clears the control and configuration
// registers to 0 and empties the queue; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module packet_fragment_planner_top (
  input  wire logic clk,
  input  wire logic rst_n,
  pfp_in_if.sink    in_ch,
  pfp_out_if.source out_ch,
  pfp_cfg_if.sink   cfg_ch
);
  import pfp_pkg::*;

  logic [MODE_BITS-1:0]   limit_mode_r;
  logic [LENGTH_BITS-1:0] max_part_size_r;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     push;
  job_t     push_job;
  logic     full;
  logic     pop;
  job_t     head;
  logic     empty;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_mode_r    <= '0;
      max_part_size_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        CFG_LIMIT_MODE:    limit_mode_r <= cfg_ch.wdata[MODE_BITS-1:0];
        CFG_MAX_PART_SIZE: max_part_size_r <= cfg_ch.wdata[LENGTH_BITS-1:0];
        default:           limit_mode_r <= limit_mode_r;
      endcase
    end
  end

  pfp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  pfp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .limit_mode    (limit_mode_r),
    .max_part_size (max_part_size_r),
    .div_req       (div_req),
    .div_rsp       (div_rsp),
    .push          (push),
    .push_job      (push_job),
    .full          (full)
  );

  pfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  pfp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
